### hdl/sft_pkg.sv
// Shared types and constants for the sphere face tessellator.
`default_nettype none
package sft_pkg;
    localparam int MAX_LEVEL = 4;
    localparam int COORD_W = 16;
    localparam int LEVEL_W = 3;
    localparam int RADIUS_W = 15;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS = 2'd1;

    localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 3'd4;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd4096;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = 3'(MAX_LEVEL);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [2:0][COORD_W-1:0] vec_t;

    typedef enum logic {
        TRI_LOWER = 1'b0,
        TRI_UPPER = 1'b1
    } tri_sel_t;

    typedef struct packed {
        logic                 load;
        logic                 point_start;
        logic [LEVEL_W-1:0]   pi;
        logic [LEVEL_W-1:0]   pj;
        logic [1:0]           slot;
        logic                 emit;
        tri_sel_t             tri_sel;
        logic                 last;
    } sft_cmd_t;

    typedef struct packed {
        logic                 point_done;
        logic                 out_free;
        logic [LEVEL_W-1:0]   level;
    } sft_status_t;
endpackage
`default_nettype wire

### hdl/sft_proj.sv
// Iterative projection of one grid point onto the sphere.
`default_nettype none
module sft_proj (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [2:0]                 wi,
    input  wire logic [2:0]                 wj,
    input  wire logic [2:0]                 wk,
    input  wire sft_pkg::vec_t              corner_a,
    input  wire sft_pkg::vec_t              corner_b,
    input  wire sft_pkg::vec_t              corner_c,
    input  wire logic [sft_pkg::RADIUS_W-1:0] radius,
    output logic                            done,
    output sft_pkg::vec_t                   result
);
    import sft_pkg::*;

    typedef enum logic [2:0] {
        P_IDLE, P_SUM, P_SHIFT, P_SQ, P_ROOT, P_MUL, P_DIV
    } pstate_t;

    pstate_t state_reg;
    logic [2:0] wi_reg, wj_reg, wk_reg;
    logic [2:0] neg_reg;
    logic [2:0][17:0] m_reg;
    logic [37:0] sq_reg;
    logic [18:0] root_reg;
    logic [20:0] rrem_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  t_reg;
    logic [34:0] num_reg;
    logic [19:0] drem_reg;
    logic [15:0] q_reg;
    logic        done_reg;
    vec_t        res_reg;

    logic signed [19:0] sum_w [3];
    logic [2:0][17:0] abs_w;
    logic [22:0] rw;
    logic [22:0] trial;
    logic [20:0] dw;
    logic [19:0] dvs;
    logic [32:0] mr;
    logic [15:0] qn;
    logic [35:0] sq_w;
    logic [34:0] num_w;

    always_comb begin
        for (int t = 0; t < 3; t++) begin
            sum_w[t] = $signed({17'd0, wi_reg}) * $signed({{4{corner_a[t][15]}}, corner_a[t]})
                     + $signed({17'd0, wj_reg}) * $signed({{4{corner_b[t][15]}}, corner_b[t]})
                     + $signed({17'd0, wk_reg}) * $signed({{4{corner_c[t][15]}}, corner_c[t]});
            abs_w[t] = sum_w[t][19] ? 18'(-sum_w[t]) : sum_w[t][17:0];
        end
        rw    = {rrem_reg, sq_reg[37:36]};
        trial = {2'b00, root_reg, 2'b01};
        dvs   = {root_reg, 1'b0};
        dw    = {drem_reg, num_reg[cnt_reg[3:0]]};
        sq_w  = m_reg[t_reg] * m_reg[t_reg];
        mr    = m_reg[t_reg] * radius;
        num_w = {1'b0, mr, 1'b0} + {16'd0, root_reg};
        qn    = (dw >= {1'b0, dvs}) ? {q_reg[14:0], 1'b1} : {q_reg[14:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                P_IDLE: begin
                    if (start) begin
                        wi_reg <= wi;
                        wj_reg <= wj;
                        wk_reg <= wk;
                        state_reg <= P_SUM;
                    end
                end
                P_SUM: begin
                    for (int t = 0; t < 3; t++) begin
                        neg_reg[t] <= sum_w[t][19];
                        m_reg[t]   <= abs_w[t];
                    end
                    state_reg <= P_SHIFT;
                end
                P_SHIFT: begin
                    if ((m_reg[0] | m_reg[1] | m_reg[2]) == 18'd0) begin
                        res_reg   <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= P_IDLE;
                    end else if (!(m_reg[0][17] | m_reg[1][17] | m_reg[2][17])) begin
                        for (int t = 0; t < 3; t++) m_reg[t] <= {m_reg[t][16:0], 1'b0};
                    end else begin
                        sq_reg    <= '0;
                        t_reg     <= 2'd0;
                        state_reg <= P_SQ;
                    end
                end
                P_SQ: begin
                    sq_reg <= sq_reg + {2'b00, sq_w};
                    if (t_reg == 2'd2) begin
                        root_reg  <= '0;
                        rrem_reg  <= '0;
                        cnt_reg   <= 5'd18;
                        state_reg <= P_ROOT;
                    end else begin
                        t_reg <= t_reg + 2'd1;
                    end
                end
                P_ROOT: begin
                    // one root bit per cycle, two radicand bits consumed
                    if (rw >= trial) begin
                        rrem_reg <= 21'(rw - trial);
                        root_reg <= {root_reg[17:0], 1'b1};
                    end else begin
                        rrem_reg <= rw[20:0];
                        root_reg <= {root_reg[17:0], 1'b0};
                    end
                    sq_reg <= {sq_reg[35:0], 2'b00};
                    if (cnt_reg == 5'd0) begin
                        t_reg     <= 2'd0;
                        state_reg <= P_MUL;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                P_MUL: begin
                    // seed the remainder with the high numerator bits
                    num_reg   <= num_w;
                    drem_reg  <= {1'b0, num_w[34:16]};
                    state_reg <= P_DIV;
                    cnt_reg   <= 5'd15;
                    q_reg     <= '0;
                end
                P_DIV: begin
                    q_reg <= qn;
                    drem_reg <= (dw >= {1'b0, dvs}) ? 20'(dw - {1'b0, dvs}) : dw[19:0];
                    if (cnt_reg == 5'd0) begin
                        res_reg[t_reg] <= neg_reg[t_reg] ? 16'(-qn) : qn;
                        if (t_reg == 2'd2) begin
                            done_reg  <= 1'b1;
                            state_reg <= P_IDLE;
                        end else begin
                            t_reg     <= t_reg + 2'd1;
                            state_reg <= P_MUL;
                        end
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                default: state_reg <= P_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

### hdl/sft_datapath.sv
// Datapath: corner and config registers, point slots, index counter, output register.
`default_nettype none
module sft_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire sft_pkg::sft_cmd_t              cmd,
    output sft_pkg::sft_status_t                status,
    input  wire logic [143:0]                   s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           cfg_wr_en,
    input  wire logic [sft_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [sft_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [159:0]                        m_tdata,
    output logic                                m_tlast
);
    import sft_pkg::*;

    logic [LEVEL_W-1:0]  level_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [15:0]         vcount_reg;
    vec_t                a_reg, b_reg, c_reg;
    vec_t                slot_reg [4];
    logic [1:0]          slot_sel_reg;
    logic                mvalid_reg;
    logic [159:0]        mdata_reg;
    logic                mlast_reg;

    logic [LEVEL_W-1:0]  level_eff;
    logic [2:0]          wk;
    logic                pdone;
    vec_t                pres;
    vec_t                v0, v1, v2;

    assign level_eff = (level_reg > LEVEL_MAX) ? LEVEL_MAX : level_reg;
    assign wk = 3'(level_eff + 3'd1 - cmd.pi - cmd.pj);

    sft_proj u_proj (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.point_start),
        .wi       (cmd.pi),
        .wj       (cmd.pj),
        .wk       (wk),
        .corner_a (a_reg),
        .corner_b (b_reg),
        .corner_c (c_reg),
        .radius   (radius_reg),
        .done     (pdone),
        .result   (pres)
    );

    always_comb begin
        v0 = (cmd.tri_sel == TRI_UPPER) ? slot_reg[1] : slot_reg[0];
        v1 = (cmd.tri_sel == TRI_UPPER) ? slot_reg[3] : slot_reg[1];
        v2 = slot_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= LEVEL_RESET;
            radius_reg <= RADIUS_RESET;
            vcount_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_LEVEL:  level_reg  <= cfg_wdata[LEVEL_W-1:0];
                    REG_RADIUS: radius_reg <= cfg_wdata[RADIUS_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                a_reg <= s_tdata[47:0];
                b_reg <= s_tdata[95:48];
                c_reg <= s_tdata[143:96];
                if (s_tuser) vcount_reg <= '0;
            end
            if (cmd.point_start) slot_sel_reg <= cmd.slot;
            if (pdone) slot_reg[slot_sel_reg] <= pres;
            if (cmd.emit) begin
                mvalid_reg <= 1'b1;
                mdata_reg  <= {vcount_reg, v2, v1, v0};
                mlast_reg  <= cmd.last;
                vcount_reg <= vcount_reg + 16'd3;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    assign status.point_done = pdone;
    assign status.out_free   = !mvalid_reg || m_tready;
    assign status.level      = level_eff;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
endmodule
`default_nettype wire

### hdl/sft_ctrl.sv
// Controller: walks the grid, orders point projections and triangle emission.
`default_nettype none
module sft_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire sft_pkg::sft_status_t status,
    output sft_pkg::sft_cmd_t         cmd
);
    import sft_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_WAIT, ST_EMIT0, ST_EMIT1
    } state_t;

    state_t state_reg;
    logic [LEVEL_W-1:0] i_reg, j_reg;
    logic [1:0] pt_reg;

    logic more_j;
    logic [1:0] last_pt;

    assign more_j  = (4'(i_reg) + 4'(j_reg)) < 4'(status.level);
    assign last_pt = more_j ? 2'd3 : 2'd2;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd = '0;
        cmd.load        = s_tready && s_tvalid;
        cmd.point_start = (state_reg == ST_START);
        cmd.slot        = pt_reg;
        cmd.pi          = 3'(i_reg + {2'b00, pt_reg[0]});
        cmd.pj          = 3'(j_reg + {2'b00, pt_reg[1]});
        cmd.tri_sel     = (state_reg == ST_EMIT1) ? TRI_UPPER : TRI_LOWER;
        cmd.emit        = ((state_reg == ST_EMIT0) || (state_reg == ST_EMIT1)) && status.out_free;
        cmd.last        = (state_reg == ST_EMIT0) && (i_reg == status.level);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            pt_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        pt_reg    <= '0;
                        state_reg <= ST_START;
                    end
                end
                ST_START: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (status.point_done) begin
                        if (pt_reg == last_pt) begin
                            state_reg <= ST_EMIT0;
                        end else begin
                            pt_reg    <= pt_reg + 2'd1;
                            state_reg <= ST_START;
                        end
                    end
                end
                ST_EMIT0, ST_EMIT1: begin
                    if (status.out_free) begin
                        if (state_reg == ST_EMIT0 && more_j) begin
                            state_reg <= ST_EMIT1;
                        end else begin
                            // advance to the next grid cell, or return to idle after the last one
                            pt_reg <= '0;
                            if (more_j) begin
                                j_reg     <= j_reg + 3'd1;
                                state_reg <= ST_START;
                            end else if (i_reg < status.level) begin
                                i_reg     <= i_reg + 3'd1;
                                j_reg     <= '0;
                                state_reg <= ST_START;
                            end else begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### hdl/sphere_face_tessellator.sv
// Top level: face in, projected triangles out, one face at a time.
// Each grid point passes through the shared projection unit (sum, up to 17 shifts, three
// squares, 19-step root, three 16-bit divisions); a zero-length point ends after the shifts.
// A grid cell needs three or four points and emits one or two triangles; a level-4 face has
// 55 points. s_tready rises the cycle after the last triangle enters the output register.
// Reset (synchronous, active low) restores level 4, radius 1.0 and clears the index.
`default_nettype none
module sphere_face_tessellator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // corner_a_x, _y, _z, corner_b_x, _y, _z, corner_c_x, _y, _z
    input  wire logic [143:0]                   s_tdata,
    // start_new_mesh
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // vert0_x, _y, _z, vert1_x, _y, _z, vert2_x, _y, _z, first_index
    output logic [159:0]                        m_tdata,
    output logic                                m_tlast,
    input  wire logic                           cfg_wr_en,
    input  wire logic [sft_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [sft_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sft_pkg::*;

    sft_cmd_t    cmd;
    sft_status_t status;

    sft_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sft_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );
endmodule
`default_nettype wire

### dv/tb_top.sv
// Testbench for the sphere face tessellator: random and directed faces, checked per triangle.
`timescale 1ns / 1ps

class tess_scoreboard;
    logic [2:0]  level;
    logic [14:0] radius;
    logic [15:0] vcount;
    logic [160:0] tri_q[$];  // {last, first_index, v2, v1, v0}
    int errors;

    function new();
        level  = sft_pkg::LEVEL_RESET;
        radius = sft_pkg::RADIUS_RESET;
        vcount = '0;
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] addr, logic [14:0] val);
        if (addr == sft_pkg::REG_LEVEL) level = val[2:0];
        else if (addr == sft_pkg::REG_RADIUS) radius = val;
    endfunction

    function void expect_tri(logic [160:0] t);
        tri_q.insert(tri_q.size(), t);
    endfunction

    function longint unsigned int_root(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Project grid point (i,j) onto the sphere; corners hold a, b, c by index.
    function logic [47:0] project(longint cr[9], int i, int j, int steps);
        longint s[3];
        longint unsigned m[3], big, n, q;
        logic [47:0] v;
        int t;
        for (t = 0; t < 3; t++) begin
            s[t] = i * cr[t] + j * cr[3+t] + (steps - i - j) * cr[6+t];
            m[t] = (s[t] < 0) ? -s[t] : s[t];
        end
        big = m[0];
        if (m[1] > big) big = m[1];
        if (m[2] > big) big = m[2];
        if (big == 0) return '0;
        while (big < (64'd1 << 17)) begin
            big <<= 1;
            for (t = 0; t < 3; t++) m[t] <<= 1;
        end
        n = int_root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (t = 0; t < 3; t++) begin
            q = (2 * m[t] * radius + n) / (2 * n);
            if (s[t] < 0) q = -q;
            v[16*t +: 16] = q[15:0];
        end
        return v;
    endfunction

    function void note_face(logic [143:0] d, logic start);
        longint cr[9];
        int steps, total, cnt, i, j;
        logic [47:0] p0, p1, p2, p3;
        for (int k = 0; k < 9; k++) cr[k] = $signed(d[16*k +: 16]);
        if (start) vcount = '0;
        steps = ((level > sft_pkg::LEVEL_MAX) ? sft_pkg::LEVEL_MAX : level) + 1;
        total = steps * steps;
        cnt = 0;
        for (i = 0; i < steps; i++) begin
            for (j = 0; j < steps - i; j++) begin
                p0 = project(cr, i, j, steps);
                p1 = project(cr, i + 1, j, steps);
                p2 = project(cr, i, j + 1, steps);
                cnt++;
                expect_tri({cnt == total, vcount, p2, p1, p0});
                vcount += 3;
                if (j + 1 < steps - i) begin
                    p3 = project(cr, i + 1, j + 1, steps);
                    cnt++;
                    expect_tri({cnt == total, vcount, p2, p3, p1});
                    vcount += 3;
                end
            end
        end
    endfunction

    function void check_tri(logic [159:0] d, logic last);
        logic [160:0] e;
        if (tri_q.size() == 0) begin
            $display("%0t: unexpected triangle %h last %b", $time, d, last);
            errors++;
            return;
        end
        e = tri_q.pop_front();
        for (int k = 0; k < 10; k++)
            if (e[16*k +: 16] !== d[16*k +: 16]) begin
                $display("%0t: field %0d expected %h actual %h", $time, k,
                         e[16*k +: 16], d[16*k +: 16]);
                errors++;
            end
        if (e[160] !== last) begin
            $display("%0t: last expected %b actual %b", $time, e[160], last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import sft_pkg::*;

    localparam longint CYCLE_LIMIT = 6_000_000;

    logic aclk, aresetn;
    logic s_tvalid, s_tready, s_tuser;
    logic [143:0] s_tdata;
    logic m_tvalid, m_tready, m_tlast;
    logic [159:0] m_tdata;
    logic cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tess_scoreboard sb = new();
    int send_idle_pct, recv_stall_pct;
    int hold_off = 0;
    longint cycles = 0;

    sphere_face_tessellator dut (.*);

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0; s_tdata <= '0; s_tuser <= 1'b0;
        cfg_wr_en <= 1'b0; cfg_addr <= '0; cfg_wdata <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Receiver: long hold-off when asked, otherwise random stalls.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) sb.check_tri(m_tdata, m_tlast);
        if (hold_off > 0) begin
            hold_off--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(addr, val);
        @(posedge aclk);
    endtask

    task automatic drain();
        while (sb.tri_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic send_face(logic [143:0] d, logic start);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_face(d, start);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(4))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            2: return 16'($signed($urandom_range(16)) - 8);
            default: return 16'($signed($urandom_range(16384)) - 8192);
        endcase
    endfunction

    function automatic logic [143:0] rand_face();
        logic [143:0] d;
        for (int k = 0; k < 9; k++) d[16*k +: 16] = rand_coord();
        // Opposite corners can give zero-length points on the grid.
        if ($urandom_range(9) == 0)
            for (int k = 0; k < 3; k++) d[96 + 16*k +: 16] = -d[16*k +: 16];
        return d;
    endfunction

    function automatic logic [143:0] directed_face(int n);
        logic [143:0] d;
        case (n)
            0: d = '0;
            1: d = {9{16'h7fff}};
            2: d = {9{16'h8000}};
            3: d = {16'h0, 16'h0, 16'h1000, 16'h0, 16'h1000, 16'h0, 16'h1000, 16'h0, 16'h0};
            4: d = {16'h0, 16'h0, 16'hf000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1000};
            5: d = {3{16'h7fff, 16'h8000, 16'h0001}};
            6: d = {16'h0001, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h0001};
            7: d = {16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                    16'h8000, 16'h7fff, 16'h8000};
            8: d = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                    16'h5555, 16'haaaa, 16'h5555};
            default: d = rand_face();
        endcase
        return d;
    endfunction

    int levels[8]  = '{4, 0, 1, 2, 7, 5, 3, 1};
    int radii[8]   = '{4096, 32767, 0, -1, 12345, 1, 2048, -1};
    int counts[8]  = '{14, 60, 30, 60, 8, 6, 40, 50};

    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        @(posedge aclk);
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            // The first phase runs on the reset values.
            if (ph != 0) begin
                write_reg(REG_LEVEL, CFG_DATA_W'(levels[ph]));
                write_reg(REG_RADIUS, (radii[ph] < 0) ? CFG_DATA_W'($urandom) :
                          CFG_DATA_W'(radii[ph]));
            end
            if (ph == 3) hold_off = 3000;
            for (int n = 0; n < counts[ph]; n++)
                send_face(ph == 0 ? directed_face(n) : rand_face(),
                          (ph == 0) ? (n == 0 || n == 9) : ($urandom_range(4) == 0));
            s_tvalid <= 1'b0;
            drain();
        end
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
